// ===== sv/tlbfs_pkg.sv =====
// Package for the text line and binary frame splitter.
// Holds the beat types, the event codes, the mode and sequencer encodings.
// No dependencies.
`default_nettype none

package tlbfs_pkg;

   // Event codes carried in event_res.
   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_BOUNDARY = 3'd1;
   localparam logic [2:0] EV_READY    = 3'd2;
   localparam logic [2:0] EV_OVERLONG = 3'd3;
   localparam logic [2:0] EV_BINARY   = 3'd4;

   // Input kinds.
   localparam logic KIND_BYTE   = 1'b0;
   localparam logic KIND_RESYNC = 1'b1;

   // Special byte values.
   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_LF  = 8'h0A;

   // Reset value of the frame limit register.
   localparam logic [15:0] FRAME_LIMIT_RESET = 16'd256;

   // One input beat.
   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic [2:0] event_res;
      logic [7:0] line_byte;
      logic       last;
   } rsp_type;

   // Receive mode, one-hot.
   typedef enum logic [2:0] {
      MODE_TEXT    = 3'b001,
      MODE_DISCARD = 3'b010,
      MODE_BINARY  = 3'b100
   } mode_type;

   // Sequencer state, one-hot.
   typedef enum logic [1:0] {
      SEQ_IDLE = 2'b01,
      SEQ_EMIT = 2'b10
   } seq_type;

endpackage

`default_nettype wire

// ===== sv/text_line_and_binary_frame_splitter.sv =====
// Top level of the text line and binary frame splitter.
// Uses tlbfs_pkg for beat types, event codes and state encodings.
// Holds the line store memory and the read-out sequencer.
`default_nettype none

// Splits a byte stream into text lines and binary frames. Each input beat
// is one received byte or a resync command. A byte that causes at most one
// result is taken directly, and the next beat is accepted as soon as the
// output register is free. A finished line is read from the single-port
// line store one entry per cycle while the result output is not stalled;
// no input is taken during that read-out. The line store needs no clearing
// after reset: only entries written since the last line end are ever read.
// The frame limit register is written through the csr port, which is
// always ready.
module text_line_and_binary_frame_splitter
   import tlbfs_pkg::*;
#(
   parameter int LINE_DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input channel.
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   // Result channel.
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   // Configuration channel.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);

   localparam int ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int LEN_W  = $clog2(LINE_DEPTH + 1);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_DEPTH);

   // State registers.
   mode_type          mode_ff, mode_in;
   seq_type           seq_ff, seq_in;
   logic [LEN_W-1:0]  line_len_ff, line_len_in;
   logic [16:0]       frame_cnt_ff, frame_cnt_in;
   logic [15:0]       limit_ff;
   logic [ADDR_W-1:0] emit_pos_ff, emit_pos_in;
   logic [ADDR_W-1:0] emit_end_ff, emit_end_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // Line store and its registered read port.
   logic [7:0]        line_mem [LINE_DEPTH];
   logic [7:0]        rd_data_ff;
   logic              mem_wr;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic              mem_rd;
   logic [ADDR_W-1:0] mem_rd_addr;

   logic        slot_free;
   logic        accept;
   logic        is_eol;
   logic [16:0] frame_inc;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((seq_ff == SEQ_IDLE) && slot_free);
   assign accept    = req_valid && !req_stall;
   assign is_eol    = (req_data.data_byte == CHAR_CR) || (req_data.data_byte == CHAR_LF);
   assign frame_inc = frame_cnt_ff + 17'd1;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // Next-state logic for the mode machine, the sequencer and the output.
   always_comb begin
      mode_in      = mode_ff;
      seq_in       = seq_ff;
      line_len_in  = line_len_ff;
      frame_cnt_in = frame_cnt_ff;
      emit_pos_in  = emit_pos_ff;
      emit_end_in  = emit_end_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_wr       = 1'b0;
      mem_wr_addr  = line_len_ff[ADDR_W-1:0];
      mem_rd       = 1'b0;
      mem_rd_addr  = '0;

      unique case (seq_ff)
         SEQ_IDLE: begin
            if (accept) begin
               if (req_data.kind == KIND_RESYNC) begin
                  line_len_in  = '0;
                  frame_cnt_in = '0;
                  mode_in      = MODE_DISCARD;
               end else begin
                  unique case (mode_ff)
                     MODE_BINARY: begin
                        if (req_data.data_byte == CHAR_NUL) begin
                           mode_in      = MODE_TEXT;
                           rsp_valid_in = 1'b1;
                           rsp_data_in  = '{EV_BINARY, 8'h00, 1'b1};
                        end else begin
                           frame_cnt_in = frame_inc;
                           if (frame_inc > {1'b0, limit_ff}) begin
                              mode_in      = MODE_DISCARD;
                              rsp_valid_in = 1'b1;
                              rsp_data_in  = '{EV_BINARY, 8'h00, 1'b1};
                           end
                        end
                     end
                     MODE_DISCARD: begin
                        if (req_data.data_byte == CHAR_NUL) begin
                           line_len_in  = '0;
                           frame_cnt_in = '0;
                           mode_in      = MODE_BINARY;
                        end else if (is_eol) begin
                           mode_in      = MODE_TEXT;
                           rsp_valid_in = 1'b1;
                           rsp_data_in  = '{EV_BOUNDARY, 8'h00, 1'b1};
                        end
                     end
                     default: begin
                        // Text mode.
                        if (req_data.data_byte == CHAR_NUL) begin
                           line_len_in  = '0;
                           frame_cnt_in = '0;
                           mode_in      = MODE_BINARY;
                        end else if (is_eol) begin
                           if (line_len_ff == '0) begin
                              rsp_valid_in = 1'b1;
                              rsp_data_in  = '{EV_BOUNDARY, 8'h00, 1'b1};
                           end else begin
                              // Start the read-out at the first stored byte.
                              mem_rd      = 1'b1;
                              mem_rd_addr = '0;
                              emit_pos_in = '0;
                              emit_end_in = ADDR_W'(line_len_ff - LEN_W'(1));
                              line_len_in = '0;
                              seq_in      = SEQ_EMIT;
                           end
                        end else if (line_len_ff < LEN_MAX) begin
                           mem_wr      = 1'b1;
                           line_len_in = line_len_ff + LEN_W'(1);
                        end else begin
                           line_len_in  = '0;
                           mode_in      = MODE_DISCARD;
                           rsp_valid_in = 1'b1;
                           rsp_data_in  = '{EV_OVERLONG, 8'h00, 1'b1};
                        end
                     end
                  endcase
               end
            end
         end
         SEQ_EMIT: begin
            // The read register holds the byte at emit_pos_ff.
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{EV_READY, rd_data_ff, emit_pos_ff == emit_end_ff};
               if (emit_pos_ff == emit_end_ff) begin
                  seq_in = SEQ_IDLE;
               end else begin
                  mem_rd      = 1'b1;
                  mem_rd_addr = emit_pos_ff + ADDR_W'(1);
                  emit_pos_in = emit_pos_ff + ADDR_W'(1);
               end
            end
         end
         default: begin
            seq_in = SEQ_IDLE;
         end
      endcase
   end

   // Line store: one write or one read per cycle, read data registered.
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         line_mem[mem_wr_addr] <= req_data.data_byte;
      end
      if (mem_rd) begin
         rd_data_ff <= line_mem[mem_rd_addr];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_TEXT;
         seq_ff       <= SEQ_IDLE;
         line_len_ff  <= '0;
         frame_cnt_ff <= '0;
         limit_ff     <= FRAME_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         seq_ff       <= seq_in;
         line_len_ff  <= line_len_in;
         frame_cnt_ff <= frame_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      emit_pos_ff <= emit_pos_in;
      emit_end_ff <= emit_end_in;
      rsp_data_ff <= rsp_data_in;
   end

   // No input beat is taken while a line is read out.
   assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SEQ_EMIT) |-> req_stall)
      else $error("input accepted during line read-out");

   // The line length never exceeds the store depth.
   assert property (@(posedge clock) disable iff (reset)
      line_len_ff <= LEN_MAX)
      else $error("line length beyond store depth");

   // Only line-ready beats carry a line byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.event_res != EV_READY)) |->
         ((rsp_data_ff.line_byte == 8'h00) && rsp_data_ff.last))
      else $error("non-line result carries a byte or lacks last");

   // Binary mode never holds a partial line.
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_BINARY) |-> (line_len_ff == '0))
      else $error("partial line kept in binary mode");

   // Read-out position stays within the line being emitted.
   assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SEQ_EMIT) |-> (emit_pos_ff <= emit_end_ff))
      else $error("read-out position past end of line");

endmodule

`default_nettype wire
